>>> rtl/cht_pkg.sv
`default_nettype none

package cht_pkg;

  // table size and per-request result cap
  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // fixed field widths
  localparam int MODE_W = 3;
  localparam int SLOT_W = 3;
  localparam int PORT_W = 16;
  localparam int SEG_W  = 2;
  localparam int KIND_W = 4;
  localparam int TRY_W  = 8;

  // configuration register indexes
  localparam logic CFG_SYN_LIMIT = 1'b0;
  localparam logic CFG_FIN_LIMIT = 1'b1;
  localparam logic [TRY_W-1:0] SYN_LIMIT_RST = 8'd5;
  localparam logic [TRY_W-1:0] FIN_LIMIT_RST = 8'd5;

  // segment types
  localparam logic [SEG_W-1:0] SEG_SYN    = 2'd0;
  localparam logic [SEG_W-1:0] SEG_SYNACK = 2'd1;
  localparam logic [SEG_W-1:0] SEG_FIN    = 2'd2;
  localparam logic [SEG_W-1:0] SEG_FINACK = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN    = 3'd0,
    MODE_CONNECT = 3'd1,
    MODE_DISCON  = 3'd2,
    MODE_CLOSE   = 3'd3,
    MODE_RECV    = 3'd4,
    MODE_TICK    = 3'd5
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPENED     = 4'd0,
    KIND_FULL       = 4'd1,
    KIND_SEND       = 4'd2,
    KIND_CONN_OK    = 4'd3,
    KIND_CONN_FAIL  = 4'd4,
    KIND_DISC_OK    = 4'd5,
    KIND_DISC_FAIL  = 4'd6,
    KIND_CLOSED     = 4'd7,
    KIND_CLOSE_FAIL = 4'd8,
    KIND_BAD_SLOT   = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    CONN_CLOSED  = 2'd0,
    CONN_SYNSENT = 2'd1,
    CONN_EST     = 2'd2,
    CONN_FINWAIT = 2'd3
  } conn_e;

  typedef enum logic [1:0] {
    WAIT_NONE    = 2'd0,
    WAIT_CONNECT = 2'd1,
    WAIT_DISCON  = 2'd2
  } wait_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    logic              used;
    conn_e             conn;
    logic [PORT_W-1:0] lport;
    logic [PORT_W-1:0] rport;
    logic [TRY_W-1:0]  tries;
    wait_e             wt;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } tbl_wr_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [SEG_W-1:0]  stype;
    logic [PORT_W-1:0] src;
    logic [PORT_W-1:0] dst;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/cht_table.sv
`default_nettype none

module cht_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [cht_pkg::IDX_W-1:0] rd_idx_i,
  output cht_pkg::entry_t                rd_o,
  output logic [cht_pkg::SLOTS-1:0]      pend_o,
  input  wire cht_pkg::tbl_wr_t          wr_i
);
  import cht_pkg::*;

  logic              used_q  [SLOTS];
  conn_e             conn_q  [SLOTS];
  logic [TRY_W-1:0]  tries_q [SLOTS];
  wait_e             wt_q    [SLOTS];
  logic [PORT_W-1:0] lport_q [SLOTS];
  logic [PORT_W-1:0] rport_q [SLOTS];

  // slot state, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i]  <= 1'b0;
        conn_q[i]  <= CONN_CLOSED;
        tries_q[i] <= '0;
        wt_q[i]    <= WAIT_NONE;
      end
    end else if (wr_i.we) begin
      used_q[wr_i.idx]  <= wr_i.ent.used;
      conn_q[wr_i.idx]  <= wr_i.ent.conn;
      tries_q[wr_i.idx] <= wr_i.ent.tries;
      wt_q[wr_i.idx]    <= wr_i.ent.wt;
    end
  end

  // ports are always written on open before use
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      lport_q[wr_i.idx] <= wr_i.ent.lport;
      rport_q[wr_i.idx] <= wr_i.ent.rport;
    end
  end

  // single read port
  always_comb begin
    rd_o.used  = used_q[rd_idx_i];
    rd_o.conn  = conn_q[rd_idx_i];
    rd_o.lport = lport_q[rd_idx_i];
    rd_o.rport = rport_q[rd_idx_i];
    rd_o.tries = tries_q[rd_idx_i];
    rd_o.wt    = wt_q[rd_idx_i];
  end

  // slots with a request waiting for the next tick
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      pend_o[i] = used_q[i] && (wt_q[i] != WAIT_NONE);
    end
  end

endmodule

`default_nettype wire

>>> rtl/cht_seq.sv
`default_nettype none

module cht_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       acc_i,
  output logic                            busy_o,
  input  wire logic [cht_pkg::MODE_W-1:0] mode_i,
  input  wire logic [cht_pkg::SLOT_W-1:0] slot_i,
  input  wire logic [cht_pkg::PORT_W-1:0] port_i,
  input  wire logic [cht_pkg::SEG_W-1:0]  seg_type_i,
  input  wire logic [cht_pkg::TRY_W-1:0]  syn_limit_i,
  input  wire logic [cht_pkg::TRY_W-1:0]  fin_limit_i,
  output logic [cht_pkg::IDX_W-1:0]       rd_idx_o,
  input  wire cht_pkg::entry_t            rd_i,
  input  wire logic [cht_pkg::SLOTS-1:0]  pend_i,
  output cht_pkg::tbl_wr_t                wr_o,
  input  wire logic                       out_free_i,
  output logic                            emit_o,
  output cht_pkg::result_t                res_o
);
  import cht_pkg::*;

  seq_state_e        state_q, state_d;
  logic [MODE_W-1:0] op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [PORT_W-1:0] port_q;
  logic [SEG_W-1:0]  stype_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOTS-1:0]  pend_q;

  logic done, step, direct, last_idx, bad_slot, higher, last_res;

  assign busy_o   = (state_q != ST_IDLE);
  assign direct   = (op_q == MODE_CONNECT) || (op_q == MODE_DISCON) || (op_q == MODE_CLOSE);
  assign rd_idx_o = direct ? IDX_W'(slot_q) : idx_q;
  assign last_idx = (idx_q == IDX_W'(SLOTS - 1));
  assign bad_slot = (32'(slot_q) >= SLOTS);
  assign higher   = ((pend_q >> idx_q) >> 1) != '0;
  assign last_res = !higher || (cnt_q == CNT_W'(MAX_RESULTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc_i) state_d = ST_RUN;
      ST_RUN:  if (done)  state_d = ST_IDLE;
    endcase
  end

  // per-cycle action of the shared slot unit
  always_comb begin
    done       = 1'b0;
    step       = 1'b0;
    emit_o     = 1'b0;
    res_o      = '0;
    res_o.slot = SLOT_W'(rd_idx_o);
    wr_o.we    = 1'b0;
    wr_o.idx   = rd_idx_o;
    wr_o.ent   = rd_i;
    if (state_q == ST_RUN) begin
      unique case (op_q)
        MODE_OPEN: begin
          if (!rd_i.used) begin
            if (out_free_i) begin
              emit_o        = 1'b1;
              res_o.kind    = KIND_OPENED;
              res_o.last    = 1'b1;
              wr_o.we       = 1'b1;
              wr_o.ent.used = 1'b1;
              wr_o.ent.conn = CONN_CLOSED;
              wr_o.ent.lport = port_q;
              wr_o.ent.rport = '0;
              wr_o.ent.tries = '0;
              wr_o.ent.wt    = WAIT_NONE;
              done          = 1'b1;
            end
          end else if (last_idx) begin
            if (out_free_i) begin
              emit_o     = 1'b1;
              res_o.kind = KIND_FULL;
              res_o.slot = '0;
              res_o.last = 1'b1;
              done       = 1'b1;
            end
          end else begin
            step = 1'b1;
          end
        end
        MODE_CONNECT, MODE_DISCON: begin
          if (out_free_i) begin
            emit_o     = 1'b1;
            res_o.last = 1'b1;
            res_o.slot = slot_q;
            done       = 1'b1;
            if (bad_slot || !rd_i.used) begin
              res_o.kind = KIND_BAD_SLOT;
            end else begin
              res_o.kind     = KIND_SEND;
              res_o.src      = rd_i.lport;
              wr_o.we        = 1'b1;
              wr_o.ent.tries = TRY_W'(1);
              if (op_q == MODE_CONNECT) begin
                res_o.stype    = SEG_SYN;
                res_o.dst      = port_q;
                wr_o.ent.rport = port_q;
                wr_o.ent.conn  = CONN_SYNSENT;
                wr_o.ent.wt    = WAIT_CONNECT;
              end else begin
                res_o.stype   = SEG_FIN;
                res_o.dst     = rd_i.rport;
                wr_o.ent.conn = CONN_FINWAIT;
                wr_o.ent.wt   = WAIT_DISCON;
              end
            end
          end
        end
        MODE_CLOSE: begin
          if (out_free_i) begin
            emit_o     = 1'b1;
            res_o.last = 1'b1;
            res_o.slot = slot_q;
            done       = 1'b1;
            if (bad_slot) begin
              res_o.kind = KIND_BAD_SLOT;
            end else if (!rd_i.used) begin
              res_o.kind = KIND_CLOSE_FAIL;
            end else begin
              res_o.kind     = KIND_CLOSED;
              wr_o.we        = 1'b1;
              wr_o.ent.used  = 1'b0;
              wr_o.ent.conn  = CONN_CLOSED;
              wr_o.ent.wt    = WAIT_NONE;
              wr_o.ent.tries = '0;
            end
          end
        end
        MODE_RECV: begin
          // first used slot whose local port matches
          if (rd_i.used && (rd_i.lport == port_q)) begin
            done = 1'b1;
            if ((stype_q == SEG_SYNACK) && (rd_i.conn == CONN_SYNSENT)) begin
              wr_o.we       = 1'b1;
              wr_o.ent.conn = CONN_EST;
            end else if ((stype_q == SEG_FINACK) && (rd_i.conn == CONN_FINWAIT)) begin
              wr_o.we       = 1'b1;
              wr_o.ent.conn = CONN_CLOSED;
            end
          end else if (last_idx) begin
            done = 1'b1;
          end else begin
            step = 1'b1;
          end
        end
        MODE_TICK: begin
          if (pend_q[idx_q]) begin
            if (out_free_i) begin
              emit_o     = 1'b1;
              res_o.last = last_res;
              done       = last_res;
              step       = !last_res;
              wr_o.we    = 1'b1;
              if (rd_i.wt == WAIT_CONNECT) begin
                if (rd_i.conn == CONN_EST) begin
                  res_o.kind  = KIND_CONN_OK;
                  wr_o.ent.wt = WAIT_NONE;
                end else if (rd_i.tries < syn_limit_i) begin
                  res_o.kind     = KIND_SEND;
                  res_o.stype    = SEG_SYN;
                  res_o.src      = rd_i.lport;
                  res_o.dst      = rd_i.rport;
                  wr_o.ent.tries = rd_i.tries + TRY_W'(1);
                end else begin
                  res_o.kind    = KIND_CONN_FAIL;
                  wr_o.ent.conn = CONN_CLOSED;
                  wr_o.ent.wt   = WAIT_NONE;
                end
              end else begin
                if (rd_i.conn == CONN_CLOSED) begin
                  res_o.kind  = KIND_DISC_OK;
                  wr_o.ent.wt = WAIT_NONE;
                end else if (rd_i.tries < fin_limit_i) begin
                  res_o.kind     = KIND_SEND;
                  res_o.stype    = SEG_FIN;
                  res_o.src      = rd_i.lport;
                  res_o.dst      = rd_i.rport;
                  wr_o.ent.tries = rd_i.tries + TRY_W'(1);
                end else begin
                  res_o.kind    = KIND_DISC_FAIL;
                  wr_o.ent.conn = CONN_CLOSED;
                  wr_o.ent.wt   = WAIT_NONE;
                end
              end
            end
          end else if (last_idx) begin
            done = 1'b1;
          end else begin
            step = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      if (acc_i) begin
        op_q   <= mode_i;
        idx_q  <= '0;
        cnt_q  <= '0;
        pend_q <= pend_i;
      end else begin
        if (step) idx_q <= idx_q + IDX_W'(1);
        if (emit_o) cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // request word
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      slot_q  <= slot_i;
      port_q  <= port_i;
      stype_q <= seg_type_i;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i) else $error("result word issued into a full output register");
  a_idle_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_o.we) else $error("table written while idle");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && res_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer still busy after final result word");
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> (state_q == ST_IDLE)) else $error("request accepted while busy");

endmodule

`default_nettype wire

>>> rtl/connection_handshake_table.sv
`default_nettype none

// Client connection slot table. One request word is taken at a time; in_stall_o stays high
// until the request has finished. Connect, disconnect and close address one slot; open,
// received segment and timer tick walk the table one slot per cycle, unless held by the
// output register, through a single shared read/compare unit, visiting up to SLOTS (8)
// slots. A tick gives one result word per pending slot, the last one flagged by last_o.
// Each result word sits in an output register, and the walk pauses at a slot that issues
// a word while that register is full and out_stall_i is high.
module connection_handshake_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [cht_pkg::TRY_W-1:0]  cfg_data_i,
  // request channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [cht_pkg::MODE_W-1:0] mode_i,
  input  wire logic [cht_pkg::SLOT_W-1:0] slot_i,
  input  wire logic [cht_pkg::PORT_W-1:0] port_i,
  input  wire logic [cht_pkg::SEG_W-1:0]  seg_type_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [cht_pkg::KIND_W-1:0]      kind_o,
  output logic [cht_pkg::SLOT_W-1:0]      slot_out_o,
  output logic [cht_pkg::SEG_W-1:0]       send_type_o,
  output logic [cht_pkg::PORT_W-1:0]      src_port_o,
  output logic [cht_pkg::PORT_W-1:0]      dst_port_o,
  output logic                            last_o
);
  import cht_pkg::*;

  logic [TRY_W-1:0] syn_limit_q, fin_limit_q;
  logic             busy, acc, out_free, emit, out_valid_q;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd;
  logic [SLOTS-1:0] pend;
  tbl_wr_t          wr;
  result_t          res, res_q;

  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  // retry limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_limit_q <= SYN_LIMIT_RST;
      fin_limit_q <= FIN_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYN_LIMIT: syn_limit_q <= cfg_data_i;
        CFG_FIN_LIMIT: fin_limit_q <= cfg_data_i;
      endcase
    end
  end

  cht_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .pend_o   (pend),
    .wr_i     (wr)
  );

  cht_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .busy_o      (busy),
    .mode_i      (mode_i),
    .slot_i      (slot_i),
    .port_i      (port_i),
    .seg_type_i  (seg_type_i),
    .syn_limit_i (syn_limit_q),
    .fin_limit_i (fin_limit_q),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .pend_i      (pend),
    .wr_o        (wr),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) res_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign slot_out_o  = res_q.slot;
  assign send_type_o = res_q.stype;
  assign src_port_o  = res_q.src;
  assign dst_port_o  = res_q.dst;
  assign last_o      = res_q.last;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
  import cht_pkg::*;

  // spare mode codes the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int GAP_PCT       = 35;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [TRY_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i;
  logic [SLOT_W-1:0] slot_i;
  logic [PORT_W-1:0] port_i;
  logic [SEG_W-1:0]  seg_type_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [KIND_W-1:0] kind_o;
  logic [SLOT_W-1:0] slot_out_o;
  logic [SEG_W-1:0]  send_type_o;
  logic [PORT_W-1:0] src_port_o;
  logic [PORT_W-1:0] dst_port_o;
  logic              last_o;

  connection_handshake_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .slot_i      (slot_i),
    .port_i      (port_i),
    .seg_type_i  (seg_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .slot_out_o  (slot_out_o),
    .send_type_o (send_type_o),
    .src_port_o  (src_port_o),
    .dst_port_o  (dst_port_o),
    .last_o      (last_o)
  );

  // shadow copy of the slot table and retry limits
  logic              used_q  [SLOTS];
  conn_e             conn_q  [SLOTS];
  logic [PORT_W-1:0] lport_q [SLOTS];
  logic [PORT_W-1:0] rport_q [SLOTS];
  logic [TRY_W-1:0]  tries_q [SLOTS];
  wait_e             wait_q  [SLOTS];
  logic [TRY_W-1:0]  syn_limit_q;
  logic [TRY_W-1:0]  fin_limit_q;

  // result words still owed by the block, oldest first
  result_t awaited[$];
  result_t head;

  int          mismatches;
  int          words_checked;
  int          requests_sent;
  bit          no_gaps;
  logic [15:0] kinds_seen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Timeout waiting for result words");
    $display("Mismatches found");
    $finish;
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void queue_word(kind_e k, int s, logic [SEG_W-1:0] st,
                                     logic [PORT_W-1:0] src, logic [PORT_W-1:0] dst);
    result_t w;
    w.kind  = k;
    w.slot  = SLOT_W'(s);
    w.stype = st;
    w.src   = src;
    w.dst   = dst;
    w.last  = 1'b0;
    awaited.push_back(w);
  endfunction

  // update the shadow table for one request and queue the words it produces
  function automatic void predict_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] s,
                                          logic [PORT_W-1:0] p, logic [SEG_W-1:0] seg);
    int      n;
    int      hit;
    bit      ok;
    result_t w;
    n   = 0;
    hit = -1;
    ok  = (int'(s) < SLOTS) && used_q[s];
    case (mode)
      MODE_OPEN: begin
        for (int i = 0; i < SLOTS; i++)
          if (!used_q[i] && hit < 0) hit = i;
        if (hit < 0) begin
          queue_word(KIND_FULL, 0, '0, '0, '0);
        end else begin
          used_q[hit]  = 1'b1;
          conn_q[hit]  = CONN_CLOSED;
          lport_q[hit] = p;
          rport_q[hit] = '0;
          tries_q[hit] = '0;
          wait_q[hit]  = WAIT_NONE;
          queue_word(KIND_OPENED, hit, '0, '0, '0);
        end
        n = 1;
      end
      MODE_CONNECT: begin
        if (!ok) begin
          queue_word(KIND_BAD_SLOT, s, '0, '0, '0);
        end else begin
          rport_q[s] = p;
          conn_q[s]  = CONN_SYNSENT;
          tries_q[s] = 8'd1;
          wait_q[s]  = WAIT_CONNECT;
          queue_word(KIND_SEND, s, SEG_SYN, lport_q[s], rport_q[s]);
        end
        n = 1;
      end
      MODE_DISCON: begin
        if (!ok) begin
          queue_word(KIND_BAD_SLOT, s, '0, '0, '0);
        end else begin
          conn_q[s]  = CONN_FINWAIT;
          tries_q[s] = 8'd1;
          wait_q[s]  = WAIT_DISCON;
          queue_word(KIND_SEND, s, SEG_FIN, lport_q[s], rport_q[s]);
        end
        n = 1;
      end
      MODE_CLOSE: begin
        if (int'(s) >= SLOTS) begin
          queue_word(KIND_BAD_SLOT, s, '0, '0, '0);
        end else if (!ok) begin
          queue_word(KIND_CLOSE_FAIL, s, '0, '0, '0);
        end else begin
          used_q[s]  = 1'b0;
          conn_q[s]  = CONN_CLOSED;
          wait_q[s]  = WAIT_NONE;
          tries_q[s] = '0;
          queue_word(KIND_CLOSED, s, '0, '0, '0);
        end
        n = 1;
      end
      MODE_RECV: begin
        // first used slot whose local port matches takes the segment
        for (int i = 0; i < SLOTS; i++)
          if (used_q[i] && lport_q[i] == p && hit < 0) hit = i;
        if (hit >= 0) begin
          if (seg == SEG_SYNACK && conn_q[hit] == CONN_SYNSENT)
            conn_q[hit] = CONN_EST;
          else if (seg == SEG_FINACK && conn_q[hit] == CONN_FINWAIT)
            conn_q[hit] = CONN_CLOSED;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
          if (!used_q[i] || wait_q[i] == WAIT_NONE) continue;
          if (wait_q[i] == WAIT_CONNECT) begin
            if (conn_q[i] == CONN_EST) begin
              wait_q[i] = WAIT_NONE;
              queue_word(KIND_CONN_OK, i, '0, '0, '0);
            end else if (tries_q[i] < syn_limit_q) begin
              tries_q[i]++;
              queue_word(KIND_SEND, i, SEG_SYN, lport_q[i], rport_q[i]);
            end else begin
              conn_q[i] = CONN_CLOSED;
              wait_q[i] = WAIT_NONE;
              queue_word(KIND_CONN_FAIL, i, '0, '0, '0);
            end
          end else begin
            if (conn_q[i] == CONN_CLOSED) begin
              wait_q[i] = WAIT_NONE;
              queue_word(KIND_DISC_OK, i, '0, '0, '0);
            end else if (tries_q[i] < fin_limit_q) begin
              tries_q[i]++;
              queue_word(KIND_SEND, i, SEG_FIN, lport_q[i], rport_q[i]);
            end else begin
              conn_q[i] = CONN_CLOSED;
              wait_q[i] = WAIT_NONE;
              queue_word(KIND_DISC_FAIL, i, '0, '0, '0);
            end
          end
          n++;
        end
      end
      default: ;
    endcase
    // flag the final word of this request
    if (n > 0) begin
      w = awaited.pop_back();
      w.last = 1'b1;
      awaited.push_back(w);
    end
  endfunction

  function automatic int any_used_slot();
    int start;
    int i;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      i = (start + k) % SLOTS;
      if (used_q[i]) return i;
    end
    return -1;
  endfunction

  // one request word; idles at random first, holds until accepted
  task automatic send_word(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] s,
                           logic [PORT_W-1:0] p, logic [SEG_W-1:0] seg);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < GAP_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    slot_i     <= s;
    port_i     <= p;
    seg_type_i <= seg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(mode, s, p, seg);
    requests_sent++;
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [TRY_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SYN_LIMIT) syn_limit_q = val;
    else fin_limit_q = val;
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [TRY_W-1:0] syn, logic [TRY_W-1:0] fin);
    settle();
    write_limit(CFG_SYN_LIMIT, syn);
    write_limit(CFG_FIN_LIMIT, fin);
  endtask

  // full handshake walk under reset limits: open, connect, disconnect, acks, ticks, full table, close
  task automatic test_directed_walk();
    send_word(MODE_OPEN, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_OPEN, 3'd5, 16'hFFFF, SEG_FINACK);
    send_word(MODE_CONNECT, 3'd0, 16'hFFFF, SEG_SYN);
    // requests on slots never opened
    send_word(MODE_CONNECT, 3'd5, 16'h1234, SEG_SYN);
    send_word(MODE_DISCON, 3'd6, 16'h0000, SEG_SYN);
    send_word(MODE_CLOSE, 3'd7, 16'h0000, SEG_SYN);
    // unmatched port, ignored types, ack in the wrong state, then a good SYN-ACK
    send_word(MODE_RECV, 3'd0, 16'h4321, SEG_SYNACK);
    send_word(MODE_RECV, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_RECV, 3'd0, 16'h0000, SEG_FIN);
    send_word(MODE_RECV, 3'd0, 16'h0000, SEG_FINACK);
    send_word(MODE_RECV, 3'd0, 16'h0000, SEG_SYNACK);
    send_word(MODE_CONNECT, 3'd1, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_SPARE_A, 3'd7, 16'hFFFF, SEG_FINACK);
    send_word(MODE_SPARE_B, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_DISCON, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_RECV, 3'd0, 16'h0000, SEG_FINACK);
    send_word(MODE_TICK, 3'd7, 16'hFFFF, SEG_FINACK);
    // fill the table, then one open too many
    for (int i = 2; i < SLOTS; i++)
      send_word(MODE_OPEN, 3'd0, PORT_W'(16'h0100 + i), SEG_SYN);
    send_word(MODE_OPEN, 3'd0, 16'h5555, SEG_SYN);
    send_word(MODE_CLOSE, 3'd3, 16'h0000, SEG_SYN);
  endtask

  // retry limits at 1, 0 and 255
  task automatic test_retry_extremes();
    set_limits(8'd1, 8'd1);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_CONNECT, 3'd2, 16'hABCD, SEG_SYN);
    send_word(MODE_DISCON, 3'd4, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    set_limits(8'd0, 8'd0);
    send_word(MODE_CONNECT, 3'd5, 16'h00FF, SEG_SYN);
    send_word(MODE_DISCON, 3'd6, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    set_limits(8'd255, 8'd255);
    send_word(MODE_CONNECT, 3'd2, 16'h8000, SEG_SYN);
    send_word(MODE_DISCON, 3'd4, 16'h0000, SEG_SYN);
    send_word(MODE_CONNECT, 3'd6, 16'h7FFF, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    send_word(MODE_RECV, 3'd0, lport_q[2], SEG_SYNACK);
    send_word(MODE_RECV, 3'd0, lport_q[4], SEG_FINACK);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
    // close drops the pending connect on slot 6
    send_word(MODE_CLOSE, 3'd6, 16'h0000, SEG_SYN);
    send_word(MODE_TICK, 3'd0, 16'h0000, SEG_SYN);
  endtask

  // mostly well-formed traffic aimed at slots in use, plus noise
  task automatic random_traffic(int count);
    int                done;
    int                pick;
    int                s;
    logic [SLOT_W-1:0] target;
    logic [PORT_W-1:0] p;
    logic [SEG_W-1:0]  t;
    done = 0;
    while (done < count) begin
      pick   = $urandom_range(0, 99);
      s      = any_used_slot();
      target = (s >= 0 && $urandom_range(0, 5) != 0) ? SLOT_W'(s)
                                                      : SLOT_W'($urandom_range(0, SLOTS - 1));
      p      = PORT_W'($urandom_range(0, 65535));
      t      = SEG_W'($urandom_range(0, 3));
      if (pick >= 96) begin
        send_word(pick[0] ? MODE_SPARE_A : MODE_SPARE_B, target, p, t);
        continue;
      end
      if (pick < 12) begin
        // some opens reuse a port already in the table
        case ($urandom_range(0, 5))
          0: p = '0;
          1: p = '1;
          2: if (s >= 0) p = lport_q[s];
          default: ;
        endcase
        send_word(MODE_OPEN, target, p, t);
      end else if (pick < 26) begin
        send_word(MODE_CONNECT, target, p, t);
      end else if (pick < 36) begin
        send_word(MODE_DISCON, target, p, t);
      end else if (pick < 43) begin
        send_word(MODE_CLOSE, target, p, t);
      end else if (pick < 68) begin
        // mostly the ack the slot is waiting for
        if (s >= 0 && $urandom_range(0, 4) != 0) begin
          p = lport_q[s];
          if ($urandom_range(0, 3) != 0)
            t = (conn_q[s] == CONN_FINWAIT) ? SEG_FINACK : SEG_SYNACK;
        end
        send_word(MODE_RECV, target, p, t);
      end else begin
        send_word(MODE_TICK, target, p, t);
      end
      done++;
    end
  endtask

  task automatic test_random_phase(logic [TRY_W-1:0] syn, logic [TRY_W-1:0] fin,
                                   int count, bit calm);
    set_limits(syn, fin);
    no_gaps = calm;
    random_traffic(count);
    no_gaps = 1'b0;
  endtask

  // result side stalls at random unless a calm phase is running
  always @(posedge clk_i)
    out_stall_i <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);

  // compare each accepted result word with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      kinds_seen[kind_o] = 1'b1;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: kind %0d slot %0d type %0d src %h dst %h last %b",
                                kind_o, slot_out_o, send_type_o, src_port_o, dst_port_o,
                                last_o));
      end else begin
        head = awaited.pop_front();
        if (head.kind !== kind_o || head.slot !== slot_out_o || head.stype !== send_type_o ||
            head.src !== src_port_o || head.dst !== dst_port_o || head.last !== last_o)
          flag_mismatch($sformatf({"expected kind %0d slot %0d type %0d src %h dst %h last %b,",
                                   " got kind %0d slot %0d type %0d src %h dst %h last %b"},
                                  head.kind, head.slot, head.stype, head.src, head.dst,
                                  head.last, kind_o, slot_out_o, send_type_o, src_port_o,
                                  dst_port_o, last_o));
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SYN_LIMIT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    mode_i      <= MODE_OPEN;
    slot_i      <= '0;
    port_i      <= '0;
    seg_type_i  <= SEG_SYN;
    out_stall_i <= 1'b0;
    mismatches    = 0;
    words_checked = 0;
    requests_sent = 0;
    no_gaps       = 1'b0;
    kinds_seen    = '0;
    syn_limit_q   = SYN_LIMIT_RST;
    fin_limit_q   = FIN_LIMIT_RST;
    for (int i = 0; i < SLOTS; i++) begin
      used_q[i]  = 1'b0;
      conn_q[i]  = CONN_CLOSED;
      lport_q[i] = '0;
      rport_q[i] = '0;
      tries_q[i] = '0;
      wait_q[i]  = WAIT_NONE;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walk();
    test_retry_extremes();
    test_random_phase(8'd3, 8'd2, 80, 1'b0);
    test_random_phase(8'd1, 8'd255, 80, 1'b1);
    test_random_phase(8'd255, 8'd1, 80, 1'b0);
    test_random_phase(8'd7, 8'd4, 80, 1'b0);
    settle();

    $display("Checked %0d result words from %0d requests, %0d of 10 result kinds seen;",
             words_checked, requests_sent, $countones(kinds_seen));
    $display("retry limits swept over 0, 1 and 255 with and without random stalls");
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching words, %0d words never seen", mismatches, awaited.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cht_pkg.sv
rtl/cht_table.sv
rtl/cht_seq.sv
rtl/connection_handshake_table.sv
sim/tb_top.sv
